FILE: src/mpa_pkg.sv
// Shared item types and field widths for the matrix priority arbiter.
`timescale 1ns / 1ps
`default_nettype none
package mpa_pkg;

	localparam int VALID_W = 8;
	localparam int PRIS_W = 32;
	localparam int TAGS_W = 64;
	localparam int FIELD_SPAN = 64;
	localparam int GRANT_IDX_W = 3;
	localparam int GRANT_TAG_W = 8;
	localparam int GRANT_PRI_W = 4;

	typedef struct packed {
		logic [VALID_W-1:0] request_valid;
		logic [PRIS_W-1:0]  request_priorities;
		logic [TAGS_W-1:0]  request_tags;
		logic               commit_grant;
	} req_item_t;

	typedef struct packed {
		logic                   grant_valid;
		logic [GRANT_IDX_W-1:0] grant_index;
		logic [GRANT_TAG_W-1:0] grant_tag;
		logic [GRANT_PRI_W-1:0] grant_priority;
	} rsp_item_t;

endpackage
`default_nettype wire

FILE: src/matrix_priority_arbiter.sv
// Matrix priority arbiter: input register, arbitration logic, result register.
// A result is offered from the result register once its item has moved on from the input register.
// Throughput: one item per cycle; a waiting result stalls the input only once
// the input register also holds an item.
// The precedence order updates when a committed round moves into the result register,
// so the item right behind it already sees the new order.
// Reset clears both valid flags and loads the order N-2 down to 0, then N-1.
`timescale 1ns / 1ps
`default_nettype none
module matrix_priority_arbiter
	import mpa_pkg::*;
#(
	parameter int NUM_INPUTS = 8,
	parameter int PRI_WIDTH  = 4,
	parameter int TAG_WIDTH  = 8
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp
);

	localparam int NPAIRS = NUM_INPUTS * (NUM_INPUTS - 1) / 2;

	req_item_t             req_s1;
	logic                  valid_s1;
	rsp_item_t             rsp_s2;
	logic                  valid_s2;
	rsp_item_t             result;
	logic [NUM_INPUTS-1:0] winner;
	logic [NPAIRS-1:0]     prec;
	logic                  advance;
	logic                  update;

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign update    = advance && req_s1.commit_grant && result.grant_valid;

	mpa_core #(
		.NUM_INPUTS (NUM_INPUTS),
		.PRI_WIDTH  (PRI_WIDTH),
		.TAG_WIDTH  (TAG_WIDTH)
	) u_core (
		.item   (req_s1),
		.prec   (prec),
		.result (result),
		.winner (winner)
	);

	mpa_matrix #(
		.NUM_INPUTS (NUM_INPUTS)
	) u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.update (update),
		.winner (winner),
		.prec   (prec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule
`default_nettype wire

FILE: src/mpa_matrix.sv
// Precedence matrix state (upper triangle) with least-recently-granted update.
`timescale 1ns / 1ps
`default_nettype none
module mpa_matrix
	import mpa_pkg::*;
#(
	parameter int NUM_INPUTS = 8
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        update,
	input  wire logic [NUM_INPUTS-1:0]                       winner,
	output logic      [NUM_INPUTS*(NUM_INPUTS-1)/2-1:0]      prec
);

	localparam int NPAIRS = NUM_INPUTS * (NUM_INPUTS - 1) / 2;

	logic [NPAIRS-1:0] prec_q;
	logic [NPAIRS-1:0] prec_next;
	logic [NPAIRS-1:0] prec_rst;

	// Bit (r,c) with r < c sits at c*(c-1)/2 + r and is set when r precedes c.
	// A committed winner w gets preceded by everyone: (r,w) set, (w,c) cleared.
	for (genvar gc = 1; gc < NUM_INPUTS; gc++) begin : g_col
		for (genvar gr = 0; gr < gc; gr++) begin : g_row
			localparam int B = gc * (gc - 1) / 2 + gr;
			assign prec_rst[B] = (gc == NUM_INPUTS - 1) ? 1'b1 : 1'b0;
			assign prec_next[B] = winner[gc] ? 1'b1 : (winner[gr] ? 1'b0 : prec_q[B]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q <= prec_rst;
		end else if (update) begin
			prec_q <= prec_next;
		end
	end

	assign prec = prec_q;

endmodule
`default_nettype wire

FILE: src/mpa_core.sv
// Combinational arbitration: highest priority wins, ties go by the precedence matrix.
`timescale 1ns / 1ps
`default_nettype none
module mpa_core
	import mpa_pkg::*;
#(
	parameter int NUM_INPUTS = 8,
	parameter int PRI_WIDTH  = 4,
	parameter int TAG_WIDTH  = 8
) (
	input  wire req_item_t                                   item,
	input  wire logic [NUM_INPUTS*(NUM_INPUTS-1)/2-1:0]      prec,
	output rsp_item_t                                        result,
	output logic      [NUM_INPUTS-1:0]                       winner
);

	localparam int IDX_W = $clog2(NUM_INPUTS);

	logic [FIELD_SPAN-1:0]                  pris_ext;
	logic [FIELD_SPAN-1:0]                  tags_ext;
	logic [NUM_INPUTS-1:0]                  req;
	logic [NUM_INPUTS-1:0][PRI_WIDTH-1:0]   pri;
	logic [NUM_INPUTS-1:0][TAG_WIDTH-1:0]   tag;
	logic [NUM_INPUTS-1:0][NUM_INPUTS-1:0]  beaten;
	logic [NUM_INPUTS-1:0]                  wins;
	logic [IDX_W-1:0]                       idx_sel;
	logic [PRI_WIDTH-1:0]                   pri_sel;
	logic [TAG_WIDTH-1:0]                   tag_sel;
	logic [31:0]                            idx_ext;
	logic [31:0]                            pri_ext;
	logic [31:0]                            tag_ext;

	assign pris_ext = FIELD_SPAN'(item.request_priorities);
	assign tags_ext = item.request_tags;

	// Unpack requesters; fields that fall beyond the packed words read as zero.
	for (genvar gk = 0; gk < NUM_INPUTS; gk++) begin : g_unpack
		localparam int PSH = gk * PRI_WIDTH;
		localparam int TSH = gk * TAG_WIDTH;
		if (gk < VALID_W) begin : g_req
			assign req[gk] = item.request_valid[gk];
		end else begin : g_noreq
			assign req[gk] = 1'b0;
		end
		if (PSH < FIELD_SPAN) begin : g_pri
			assign pri[gk] = PRI_WIDTH'(pris_ext >> PSH);
		end else begin : g_nopri
			assign pri[gk] = '0;
		end
		if (TSH < FIELD_SPAN) begin : g_tag
			assign tag[gk] = TAG_WIDTH'(tags_ext >> TSH);
		end else begin : g_notag
			assign tag[gk] = '0;
		end
	end

	// beaten[k][i] is set when requester i rules out requester k.
	for (genvar gk = 0; gk < NUM_INPUTS; gk++) begin : g_cand
		for (genvar gi = 0; gi < NUM_INPUTS; gi++) begin : g_rival
			if (gi == gk) begin : g_self
				assign beaten[gk][gi] = 1'b0;
			end else begin : g_other
				localparam int LO = (gi < gk) ? gi : gk;
				localparam int HI = (gi < gk) ? gk : gi;
				localparam int B = HI * (HI - 1) / 2 + LO;
				logic ahead;
				assign ahead = (gi < gk) ? prec[B] : !prec[B];
				assign beaten[gk][gi] = req[gi] &&
					((pri[gi] > pri[gk]) || ((pri[gi] == pri[gk]) && ahead));
			end
		end
		assign wins[gk] = req[gk] && !(|beaten[gk]);
	end

	assign winner = wins & (~wins + NUM_INPUTS'(1));

	always_comb begin
		idx_sel = '0;
		pri_sel = '0;
		tag_sel = '0;
		for (int k = 0; k < NUM_INPUTS; k++) begin
			if (winner[k]) begin
				idx_sel = idx_sel | IDX_W'(k);
				pri_sel = pri_sel | pri[k];
				tag_sel = tag_sel | tag[k];
			end
		end
	end

	assign idx_ext = 32'(idx_sel);
	assign pri_ext = 32'(pri_sel);
	assign tag_ext = 32'(tag_sel);

	assign result.grant_valid    = |winner;
	assign result.grant_index    = idx_ext[GRANT_IDX_W-1:0];
	assign result.grant_tag      = tag_ext[GRANT_TAG_W-1:0];
	assign result.grant_priority = pri_ext[GRANT_PRI_W-1:0];

endmodule
`default_nettype wire
